// ===== rtl/yuv_pixel_landmark_classifier_macros.svh =====
// Assertion helpers for the landmark classifier
`ifndef YUV_PIXEL_LANDMARK_CLASSIFIER_MACROS_SVH
`define YUV_PIXEL_LANDMARK_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
`define YPLC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("yplc assertion failed");
`define YPLC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("yplc assertion failed");
`else
`define YPLC_ASSERT(lbl, prop)
`define YPLC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/yplc_pkg.sv =====
`timescale 1ns / 1ps
package yplc_pkg;
	localparam int unsigned HUE_FULL  = 2880;
	localparam int unsigned HUE_SIXTH = 480;
	localparam int unsigned HUE_SLOTS = 6;
	localparam int unsigned COEF_RV   = 6537;
	localparam int unsigned COEF_GU   = 3330;
	localparam int unsigned COEF_GV   = 1631;
	localparam int unsigned COEF_BU   = 8262;

	localparam logic [2:0] REG_SAT  = 3'd0;
	localparam logic [2:0] REG_VAL  = 3'd1;
	localparam logic [2:0] REG_SUM  = 3'd2;
	localparam logic [2:0] REG_DIST = 3'd3;
	localparam logic [2:0] REG_CNT  = 3'd4;
	localparam logic [2:0] REG_HUES = 3'd5;

	localparam logic [1:0] MAX_RED   = 2'd0;
	localparam logic [1:0] MAX_GREEN = 2'd1;
	localparam logic [1:0] MAX_BLUE  = 2'd2;

	typedef struct packed {
		logic       grey;
		logic [1:0] sel;
		logic       neg;
	} hue_side_t;

	function automatic logic [7:0] chan_clamp(input logic signed [23:0] x);
		logic [23:0] t;
		logic [11:0] r;
		begin
			t = {1'b0, x[22:0]} + 24'd2048;
			r = t[23:12];
			if (x[23])
				chan_clamp = 8'd0;
			else if (r > 12'd255)
				chan_clamp = 8'd255;
			else
				chan_clamp = r[7:0];
		end
	endfunction
endpackage

// ===== rtl/yplc_div.sv =====
`timescale 1ns / 1ps
module yplc_div #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 9,
	parameter int Q_W   = 11,
	parameter int PAY_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [PAY_W-1:0] pay,
	output logic             out_vld,
	output logic [Q_W-1:0]   quo,
	output logic [PAY_W-1:0] pay_out
);
	localparam int W = NUM_W + DEN_W + Q_W;

	logic [W-1:0]     rem_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	logic [PAY_W-1:0] pay_s [Q_W+1];
	logic             vld_s [Q_W+1];

	assign rem_s[0] = W'(num);
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign pay_s[0] = pay;
	assign vld_s[0] = in_vld;

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		localparam int B = Q_W - 1 - i;
		logic [W-1:0] shd;
		logic         ge;
		assign shd = W'(den_s[i]) << B;
		assign ge  = rem_s[i] >= shd;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - shd : rem_s[i];
				q_s[i+1]   <= q_s[i] | (Q_W'(ge) << B);
				den_s[i+1] <= den_s[i];
				pay_s[i+1] <= pay_s[i];
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign quo     = q_s[Q_W];
	assign pay_out = pay_s[Q_W];
endmodule

// ===== rtl/yuv_pixel_landmark_classifier.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; the two 11-stage dividers take one quotient bit a stage.
// The whole pipeline holds while a result waits on m_tready.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
module yuv_pixel_landmark_classifier #(
	parameter int MAX_LANDMARKS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // luma[7:0], chroma_blue[15:8], chroma_red[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	// landmark_index[2:0], is_candidate[3], hue_eighths[15:4], saturation[26:16],
	// brightness[37:27], zero[39:38]
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [53:0] cfg_data
);
	import yplc_pkg::*;

	localparam int Q_W = 11;

	logic [10:0] sat_thr_q, val_thr_q;
	logic [11:0] sum_thr_q;
	logic [22:0] dist_thr_q;
	logic [2:0]  cnt_q;
	logic [53:0] hues_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_thr_q  <= 11'd358;
			val_thr_q  <= 11'd287;
			sum_thr_q  <= 12'd717;
			dist_thr_q <= 23'd19200;
			cnt_q      <= 3'd6;
			hues_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAT:  sat_thr_q  <= cfg_data[10:0];
				REG_VAL:  val_thr_q  <= cfg_data[10:0];
				REG_SUM:  sum_thr_q  <= cfg_data[11:0];
				REG_DIST: dist_thr_q <= cfg_data[22:0];
				REG_CNT:  cnt_q      <= cfg_data[2:0];
				REG_HUES: hues_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en, out_vld;
	assign en       = !out_vld || m_tready;
	assign s_tready = en;

	// stage 1: colour matrix products
	logic signed [9:0]  u10, v10;
	logic signed [23:0] y24, xr_c, xg_c, xb_c;
	logic signed [23:0] xr_s1, xg_s1, xb_s1;
	logic               vld_s1;

	assign u10  = $signed({2'b0, s_tdata[15:8]}) - 10'sd128;
	assign v10  = $signed({2'b0, s_tdata[23:16]}) - 10'sd128;
	assign y24  = $signed({4'b0, s_tdata[7:0], 12'b0});
	assign xr_c = y24 + v10 * $signed(24'(COEF_RV));
	assign xg_c = y24 - u10 * $signed(24'(COEF_GU)) - v10 * $signed(24'(COEF_GV));
	assign xb_c = y24 + u10 * $signed(24'(COEF_BU));

	// stage 2: clamp and order
	logic [7:0] r_c, g_c, b_c, mx_c, mn_c;
	logic [1:0] sel_c;
	logic [7:0] r_s2, g_s2, b_s2, mx_s2, mn_s2;
	logic [1:0] sel_s2;
	logic       vld_s2;

	always_comb begin
		r_c = chan_clamp(xr_s1);
		g_c = chan_clamp(xg_s1);
		b_c = chan_clamp(xb_s1);
		mx_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		mn_c = r_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
		if (mx_c == r_c)
			sel_c = MAX_RED;
		else if (mx_c == g_c)
			sel_c = MAX_GREEN;
		else
			sel_c = MAX_BLUE;
	end

	// stage 3: divider operands and brightness
	logic [7:0]        d_c, mag_c;
	logic signed [8:0] diff_c;
	logic [10:0]       t_c, val_c;
	logic [2:0]        vq_c;
	logic [17:0]       hnum_c, snum_c;
	logic [8:0]        hden_c;
	logic [7:0]        sden_c;
	hue_side_t         side_c;

	always_comb begin
		d_c = mx_s2 - mn_s2;
		case (sel_s2)
			MAX_RED:   diff_c = $signed({1'b0, g_s2}) - $signed({1'b0, b_s2});
			MAX_GREEN: diff_c = $signed({1'b0, b_s2}) - $signed({1'b0, r_s2});
			default:   diff_c = $signed({1'b0, r_s2}) - $signed({1'b0, g_s2});
		endcase
		mag_c = diff_c[8] ? 8'(-diff_c) : diff_c[7:0];
		side_c.grey = (d_c == 8'd0);
		side_c.sel  = sel_s2;
		side_c.neg  = diff_c[8];
		if (d_c == 8'd0) begin
			hnum_c = '0;
			hden_c = 9'd1;
		end else begin
			hnum_c = 18'(mag_c) * 18'(2 * HUE_SIXTH) + 18'(d_c);
			hden_c = {d_c, 1'b0};
		end
		snum_c = {d_c, 10'b0} + 18'(mx_s2[7:1]);
		sden_c = (mx_s2 == 8'd0) ? 8'd1 : mx_s2;
		t_c = {1'b0, mx_s2, 2'b0} + 11'd127;
		if (t_c >= 11'd1020)     vq_c = 3'd4;
		else if (t_c >= 11'd765) vq_c = 3'd3;
		else if (t_c >= 11'd510) vq_c = 3'd2;
		else if (t_c >= 11'd255) vq_c = 3'd1;
		else                     vq_c = 3'd0;
		val_c = {1'b0, mx_s2, 2'b0} + 11'(vq_c);
	end

	logic [17:0] hnum_s3, snum_s3;
	logic [8:0]  hden_s3;
	logic [7:0]  sden_s3;
	hue_side_t   side_s3;
	logic [10:0] val_s3;
	logic        vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s1   <= xr_c;
			xg_s1   <= xg_c;
			xb_s1   <= xb_c;
			r_s2    <= r_c;
			g_s2    <= g_c;
			b_s2    <= b_c;
			mx_s2   <= mx_c;
			mn_s2   <= mn_c;
			sel_s2  <= sel_c;
			hnum_s3 <= hnum_c;
			hden_s3 <= hden_c;
			snum_s3 <= snum_c;
			sden_s3 <= sden_c;
			side_s3 <= side_c;
			val_s3  <= val_c;
		end
	end

	logic             hvld, svld;
	logic [Q_W-1:0]   hq, sq;
	hue_side_t        side_d;
	logic [10:0]      val_d;

	yplc_div #(.NUM_W(18), .DEN_W(9), .Q_W(Q_W), .PAY_W($bits(hue_side_t))) u_hue_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.num(hnum_s3), .den(hden_s3), .pay(side_s3),
		.out_vld(hvld), .quo(hq), .pay_out(side_d)
	);

	yplc_div #(.NUM_W(18), .DEN_W(8), .Q_W(Q_W), .PAY_W(11)) u_sat_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s3),
		.num(snum_s3), .den(sden_s3), .pay(val_s3),
		.out_vld(svld), .quo(sq), .pay_out(val_d)
	);

	// stage 4: hue assembly and thresholds
	logic signed [13:0] base_c, hs_c;
	logic [11:0]        hue_c;
	logic               cand_c;

	always_comb begin
		case (side_d.sel)
			MAX_RED:   base_c = 14'sd0;
			MAX_GREEN: base_c = 14'(2 * HUE_SIXTH);
			default:   base_c = 14'(4 * HUE_SIXTH);
		endcase
		hs_c = side_d.neg ? base_c - $signed({3'b0, hq}) : base_c + $signed({3'b0, hq});
		if (hs_c < 0)
			hs_c = hs_c + 14'(HUE_FULL);
		hue_c = side_d.grey ? 12'd0 : hs_c[11:0];
		cand_c = (sq >= sat_thr_q) && (val_d >= val_thr_q) &&
			({1'b0, sq} + {1'b0, val_d} >= sum_thr_q);
	end

	logic [11:0] hue_s4, hue_s5, hue_s6;
	logic [10:0] sat_s4, sat_s5, sat_s6, val_s4, val_s5, val_s6;
	logic        cand_s4, cand_s5, cand_s6;
	logic        vld_s4, vld_s5, vld_s6;

	// stages 5 and 6: circular distance per landmark, then its square
	logic [12:0] amin_s5 [MAX_LANDMARKS];
	logic [25:0] sqd_s6  [MAX_LANDMARKS];

	for (genvar k = 0; k < MAX_LANDMARKS; k++) begin : g_lane
		logic [8:0]         lm;
		logic signed [13:0] dl, a0, a1, a2, m;
		if (k < HUE_SLOTS) begin : g_hue
			assign lm = hues_q[9*k +: 9];
		end else begin : g_zero
			assign lm = 9'd0;
		end
		always_comb begin
			dl = $signed({2'b0, hue_s4}) - $signed({2'b0, lm, 3'b0});
			a0 = dl[13] ? -dl : dl;
			a1 = dl - 14'(HUE_FULL);
			a1 = a1[13] ? -a1 : a1;
			a2 = dl + 14'(HUE_FULL);
			a2 = a2[13] ? -a2 : a2;
			m = a0;
			if (a1 < m) m = a1;
			if (a2 < m) m = a2;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				amin_s5[k] <= m[12:0];
				sqd_s6[k]  <= 26'(amin_s5[k]) * 26'(amin_s5[k]);
			end
		end
	end

	// stage 7: nearest landmark, earliest wins ties
	logic [25:0] best_c;
	logic [2:0]  idx_c;

	always_comb begin
		best_c = sqd_s6[0];
		idx_c  = 3'd0;
		for (int k = 1; k < MAX_LANDMARKS; k++) begin
			if (3'(k) < cnt_q && sqd_s6[k] < best_c) begin
				best_c = sqd_s6[k];
				idx_c  = 3'(k);
			end
		end
		if (!cand_s6 || best_c >= 26'(dist_thr_q))
			idx_c = 3'd0;
	end

	logic [2:0]  idx_s7;
	logic        cand_s7;
	logic [11:0] hue_s7;
	logic [10:0] sat_s7, val_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s4  <= hvld && svld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			out_vld <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s4  <= hue_c;
			sat_s4  <= sq;
			val_s4  <= val_d;
			cand_s4 <= cand_c;
			hue_s5  <= hue_s4;
			sat_s5  <= sat_s4;
			val_s5  <= val_s4;
			cand_s5 <= cand_s4;
			hue_s6  <= hue_s5;
			sat_s6  <= sat_s5;
			val_s6  <= val_s5;
			cand_s6 <= cand_s5;
			idx_s7  <= idx_c;
			cand_s7 <= cand_s6;
			hue_s7  <= hue_s6;
			sat_s7  <= sat_s6;
			val_s7  <= val_s6;
		end
	end

	assign m_tvalid = out_vld;
	assign m_tdata  = {2'b0, val_s7, sat_s7, hue_s7, cand_s7, idx_s7};

`include "yuv_pixel_landmark_classifier_macros.svh"
	`YPLC_ASSERT(a_match_is_cand, !out_vld || idx_s7 == 3'd0 || cand_s7)
	`YPLC_ASSERT(a_idx_range, !out_vld || 32'(idx_s7) < MAX_LANDMARKS)
	`YPLC_ASSERT(a_hue_range, !out_vld || hue_s7 < 12'(HUE_FULL))
	`YPLC_ASSERT(a_div_aligned, hvld == svld)
	`YPLC_ASSERT_NEXT(a_sv_range, out_vld, !out_vld || (sat_s7 <= 11'd1024 && val_s7 <= 11'd1024))
endmodule
